@@ rtl/core/ppm_pkg.sv @@
// Shared types and constants of the pedal plausibility monitor.
package ppm_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int PCT_W           = 7;
    localparam int OUT_W           = 24;
    localparam int TOL_W           = 7;
    localparam int IDX_W           = 3;
    localparam int CH_W            = 2;
    localparam int STEP_W          = 3;
    localparam int NUM_CH          = 3;

    // Register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_T1_MIN = 3'd0;
    localparam logic [IDX_W-1:0] REG_T1_MAX = 3'd1;
    localparam logic [IDX_W-1:0] REG_T2_MIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_T2_MAX = 3'd3;
    localparam logic [IDX_W-1:0] REG_BR_MIN = 3'd4;
    localparam logic [IDX_W-1:0] REG_BR_MAX = 3'd5;
    localparam logic [IDX_W-1:0] REG_TOL    = 3'd6;

    // Channel numbers
    localparam logic [CH_W-1:0] CH_T1 = 2'd0;
    localparam logic [CH_W-1:0] CH_T2 = 2'd1;
    localparam logic [CH_W-1:0] CH_BR = 2'd2;

    localparam int RST_T1_MIN = 993;
    localparam int RST_T1_MAX = 2482;
    localparam int RST_T2_MIN = 497;
    localparam int RST_T2_MAX = 1241;
    localparam int RST_BR_MAX = 0;
    localparam int RST_TOL    = 10;

    localparam logic [PCT_W-1:0] FULL_PERCENT    = 7'd100;
    localparam logic [PCT_W-1:0] THROTTLE_ACTIVE = 7'd5;
    localparam logic [PCT_W-1:0] BRAKE_ACTIVE    = 7'd25;

    // Top quotient bit position of the divider, where the divide steps start
    localparam logic [STEP_W-1:0] DIV_TOP = 3'd6;

    typedef struct packed {
        logic            load;
        logic            upd;
        logic            div;
        logic            last;
        logic            fin;
        logic [CH_W-1:0] ch;
    } ppm_cmd_t;

    typedef struct packed {
        logic out_free;
    } ppm_status_t;

endpackage

@@ rtl/core/ppm_ctrl.sv @@
// Sequencer of the pedal plausibility monitor: channel update, divide steps, result.
module ppm_ctrl
    import ppm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ppm_status_t status,
    output ppm_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= CH_T1;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    ch_next    = CH_T1;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                step_next  = DIV_TOP;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div   = 1'b1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    cmd.last = 1'b1;
                    if (ch_reg == CH_BR)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_UPD;
                    end
                end
            end
            S_FIN:
            begin
                // hold the result until the output slot is free
                if (status.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/ppm_datapath.sv @@
// Datapath: limit registers, channel levels, shared divider and output register.
module ppm_datapath
    import ppm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [IDX_W-1:0]       cfg_index,
    input  logic [SAMPLE_BITS-1:0] cfg_data,
    input  logic [SAMPLE_BITS-1:0] t1_sample,
    input  logic [SAMPLE_BITS-1:0] t2_sample,
    input  logic [SAMPLE_BITS-1:0] br_sample,
    input  ppm_cmd_t               cmd,
    output ppm_status_t            status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_W-1:0]       out_data
);

    localparam int NW = SAMPLE_BITS + PCT_W;

    logic [SAMPLE_BITS-1:0] lo_reg  [NUM_CH];
    logic [SAMPLE_BITS-1:0] hi_reg  [NUM_CH];
    logic [SAMPLE_BITS-1:0] lvl_reg [NUM_CH];
    logic [SAMPLE_BITS-1:0] smp_reg [NUM_CH];
    logic [PCT_W-1:0]       pct_reg [NUM_CH];
    logic [TOL_W-1:0]       tol_reg;
    logic [NW-1:0]          rem_reg;
    logic [NW-1:0]          dvs_reg;
    logic [PCT_W-1:0]       q_reg;
    logic                   zero_reg;
    logic                   neg_reg;
    logic                   brake_ok_reg;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg;

    // channel update
    logic [SAMPLE_BITS-1:0] lo_sel, hi_sel, avg, clamp_lo, lvl_new, delta, span;
    logic [SAMPLE_BITS:0]   sum;
    logic [NW-1:0]          num;

    // divide step
    logic [NW:0]            trial;
    logic                   ge;
    logic [PCT_W-1:0]       q_next;
    logic [PCT_W-1:0]       pct_new;

    // result
    logic [PCT_W-1:0]       diff;
    logic                   agree;
    logic                   brake_ok_next;

    always_comb
    begin
        lo_sel   = lo_reg[cmd.ch];
        hi_sel   = hi_reg[cmd.ch];
        sum      = {1'b0, lvl_reg[cmd.ch]} + {1'b0, smp_reg[cmd.ch]};
        avg      = sum[SAMPLE_BITS:1];
        clamp_lo = (avg < lo_sel) ? lo_sel : avg;
        lvl_new  = (clamp_lo > hi_sel) ? hi_sel : clamp_lo;
        delta    = lvl_new - lo_sel;
        span     = hi_sel - lo_sel;
        num      = NW'(delta) * NW'(FULL_PERCENT);

        trial    = {1'b0, rem_reg} - {1'b0, dvs_reg};
        ge       = !trial[NW];
        q_next   = {q_reg[PCT_W-2:0], ge};
        if (zero_reg)
        begin
            pct_new = '0;
        end
        else if (neg_reg)
        begin
            pct_new = FULL_PERCENT;
        end
        else
        begin
            pct_new = q_next;
        end

        diff  = (pct_reg[CH_T1] > pct_reg[CH_T2]) ? (pct_reg[CH_T1] - pct_reg[CH_T2])
                                                  : (pct_reg[CH_T2] - pct_reg[CH_T1]);
        agree = (diff <= tol_reg);
        if ((pct_reg[CH_T1] > THROTTLE_ACTIVE) && (pct_reg[CH_BR] > BRAKE_ACTIVE))
        begin
            brake_ok_next = 1'b0;
        end
        else if (pct_reg[CH_BR] == '0)
        begin
            brake_ok_next = 1'b1;
        end
        else
        begin
            brake_ok_next = brake_ok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg[CH_T1] <= SAMPLE_BITS'(RST_T1_MIN);
            hi_reg[CH_T1] <= SAMPLE_BITS'(RST_T1_MAX);
            lo_reg[CH_T2] <= SAMPLE_BITS'(RST_T2_MIN);
            hi_reg[CH_T2] <= SAMPLE_BITS'(RST_T2_MAX);
            lo_reg[CH_BR] <= '1;
            hi_reg[CH_BR] <= SAMPLE_BITS'(RST_BR_MAX);
            tol_reg       <= TOL_W'(RST_TOL);
            for (int i = 0; i < NUM_CH; i++)
            begin
                lvl_reg[i] <= '0;
            end
            brake_ok_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    REG_T1_MIN: lo_reg[CH_T1] <= cfg_data;
                    REG_T1_MAX: hi_reg[CH_T1] <= cfg_data;
                    REG_T2_MIN: lo_reg[CH_T2] <= cfg_data;
                    REG_T2_MAX: hi_reg[CH_T2] <= cfg_data;
                    REG_BR_MIN: lo_reg[CH_BR] <= cfg_data;
                    REG_BR_MAX: hi_reg[CH_BR] <= cfg_data;
                    REG_TOL:    tol_reg       <= cfg_data[TOL_W-1:0];
                    default:    ;
                endcase
            end
            if (cmd.upd)
            begin
                lvl_reg[cmd.ch] <= lvl_new;
            end
            if (cmd.fin)
            begin
                brake_ok_reg  <= brake_ok_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            smp_reg[CH_T1] <= t1_sample;
            smp_reg[CH_T2] <= t2_sample;
            smp_reg[CH_BR] <= br_sample;
        end
        if (cmd.upd)
        begin
            rem_reg  <= num;
            dvs_reg  <= NW'({span, 6'b0});
            q_reg    <= '0;
            zero_reg <= (lo_sel == hi_sel);
            neg_reg  <= (lo_sel > hi_sel);
        end
        if (cmd.div)
        begin
            // restoring divide: one quotient bit a cycle, divisor walks right
            if (ge)
            begin
                rem_reg <= trial[NW-1:0];
            end
            dvs_reg <= dvs_reg >> 1;
            q_reg   <= q_next;
        end
        if (cmd.last)
        begin
            pct_reg[cmd.ch] <= pct_new;
        end
        if (cmd.fin)
        begin
            out_data_reg <= {1'b0, brake_ok_next, agree,
                             pct_reg[CH_BR], pct_reg[CH_T2], pct_reg[CH_T1]};
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

@@ rtl/core/pedal_plausibility_monitor_top.sv @@
// A new request is accepted only in the idle state, after the previous result is loaded;
// the shared 7-step restoring divider runs once per channel, each run after one update
// state, and one result state follows.
// A result waiting in the output register stalls the next request only in its result state.
// Reset (rst_n low, asynchronous): limits and tolerance to defaults, levels to zero,
// brake plausibility latch set, output empty.
module pedal_plausibility_monitor_top
    import ppm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wen,
    input  logic [IDX_W-1:0]                      cfg_index,
    input  logic [SAMPLE_BITS-1:0]                cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // throttle1_sample, throttle2_sample, brake_sample, zero pad
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // throttle1_percent, throttle2_percent, brake_percent, throttles_agree,
    // brake_ok, zero pad
    output logic [OUT_W-1:0]                      m_axis_tdata
);

    ppm_cmd_t    cmd;
    ppm_status_t status;

    ppm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ppm_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .t1_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .t2_sample (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .br_sample (s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while previous one still in work");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.fin))
        else $error("output valid without a finished result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over a pending output");

    a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] <= FULL_PERCENT)
                       && (m_axis_tdata[13:7] <= FULL_PERCENT)
                       && (m_axis_tdata[20:14] <= FULL_PERCENT))
        else $error("percent out of range");

endmodule

@@ test/pedal_plausibility_monitor_checker.sv @@
// Pedal monitor checker: tracks settings, predicts each reading set and compares results.
module pedal_plausibility_monitor_checker
    import ppm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wen,
    input  logic [IDX_W-1:0]           cfg_index,
    input  logic [SAMPLE_BITS_DEF-1:0] cfg_data,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    // throttle1_sample, throttle2_sample, brake_sample, zero pad
    input  logic [39:0]                s_axis_tdata,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // throttle1_percent, throttle2_percent, brake_percent, throttles_agree,
    // brake_ok, zero pad
    input  logic [OUT_W-1:0]           m_axis_tdata,
    output int                         errors,
    output int                         results_seen,
    output int                         pending
);

    typedef struct packed {
        logic             brake_ok;
        logic             agree;
        logic [PCT_W-1:0] br_pct;
        logic [PCT_W-1:0] t2_pct;
        logic [PCT_W-1:0] t1_pct;
    } pedal_result_t;

    logic [SAMPLE_BITS_DEF-1:0] lo_lim [NUM_CH];
    logic [SAMPLE_BITS_DEF-1:0] hi_lim [NUM_CH];
    logic [SAMPLE_BITS_DEF-1:0] level  [NUM_CH];
    logic [TOL_W-1:0]           tol;
    logic                       brake_latch;
    int                         mismatches;
    pedal_result_t              expected_readings [$];

    // Average with the stored level, clamp to min then max, scale to percent.
    function automatic logic [PCT_W-1:0] track_channel(input logic [CH_W-1:0] ch,
                                                       input logic [SAMPLE_BITS_DEF-1:0] sample);
        logic [SAMPLE_BITS_DEF:0]   sum;
        logic [SAMPLE_BITS_DEF-1:0] v;
        int                         span;
        int                         num;
        sum = {1'b0, level[ch]} + {1'b0, sample};
        v = sum[SAMPLE_BITS_DEF:1];
        if (v < lo_lim[ch]) v = lo_lim[ch];
        if (v > hi_lim[ch]) v = hi_lim[ch];
        level[ch] = v;
        span = int'(hi_lim[ch]) - int'(lo_lim[ch]);
        if (span == 0)
            return '0;
        num = (int'(v) - int'(lo_lim[ch])) * int'(FULL_PERCENT);
        return PCT_W'(num / span);
    endfunction

    function automatic pedal_result_t predict_readings(input logic [39:0] req);
        pedal_result_t    r;
        logic [PCT_W-1:0] diff;
        r.t1_pct = track_channel(CH_T1, req[11:0]);
        r.t2_pct = track_channel(CH_T2, req[23:12]);
        r.br_pct = track_channel(CH_BR, req[35:24]);
        diff = (r.t1_pct > r.t2_pct) ? r.t1_pct - r.t2_pct : r.t2_pct - r.t1_pct;
        r.agree = (diff <= tol);
        // Drop on throttle plus brake, recover only on full brake release
        if (r.t1_pct > THROTTLE_ACTIVE && r.br_pct > BRAKE_ACTIVE)
            brake_latch = 1'b0;
        else if (r.br_pct == '0)
            brake_latch = 1'b1;
        r.brake_ok = brake_latch;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_lim[CH_T1] = SAMPLE_BITS_DEF'(RST_T1_MIN);
            hi_lim[CH_T1] = SAMPLE_BITS_DEF'(RST_T1_MAX);
            lo_lim[CH_T2] = SAMPLE_BITS_DEF'(RST_T2_MIN);
            hi_lim[CH_T2] = SAMPLE_BITS_DEF'(RST_T2_MAX);
            lo_lim[CH_BR] = '1;
            hi_lim[CH_BR] = SAMPLE_BITS_DEF'(RST_BR_MAX);
            for (int i = 0; i < NUM_CH; i++)
                level[i] = '0;
            tol = TOL_W'(RST_TOL);
            brake_latch = 1'b1;
            mismatches = 0;
            expected_readings.delete();
            errors <= 0;
            results_seen <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_T1_MIN: lo_lim[CH_T1] = cfg_data;
                    REG_T1_MAX: hi_lim[CH_T1] = cfg_data;
                    REG_T2_MIN: lo_lim[CH_T2] = cfg_data;
                    REG_T2_MAX: hi_lim[CH_T2] = cfg_data;
                    REG_BR_MIN: lo_lim[CH_BR] = cfg_data;
                    REG_BR_MAX: hi_lim[CH_BR] = cfg_data;
                    REG_TOL:    tol = cfg_data[TOL_W-1:0];
                    default:    ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_readings.push_back(predict_readings(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $error("result with no request outstanding: %h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    pedal_result_t want;
                    pedal_result_t got;
                    want = expected_readings.pop_front();
                    got = m_axis_tdata[$bits(pedal_result_t)-1:0];
                    check_field("throttle1_percent", int'(want.t1_pct), int'(got.t1_pct));
                    check_field("throttle2_percent", int'(want.t2_pct), int'(got.t2_pct));
                    check_field("brake_percent", int'(want.br_pct), int'(got.br_pct));
                    check_field("throttles_agree", int'(want.agree), int'(got.agree));
                    check_field("brake_ok", int'(want.brake_ok), int'(got.brake_ok));
                end
                results_seen <= results_seen + 1;
            end
            errors <= mismatches;
            pending <= expected_readings.size();
        end
    end

endmodule

@@ test/tb_pedal_plausibility_monitor_top.sv @@
// Testbench top of the pedal monitor: clock, reset, stimulus, flow control and verdict.
module tb_pedal_plausibility_monitor_top;
    import ppm_pkg::*;

    localparam int                SBITS          = SAMPLE_BITS_DEF;
    localparam int                FULL_SCALE     = (1 << SBITS) - 1;
    localparam logic [IDX_W-1:0]  REG_UNUSED     = 3'd7;
    localparam int                PHASES         = 8;
    localparam int                PHASE_ITEMS    = 250;
    localparam int                HOLD_OFF       = 400;
    localparam int                WATCHDOG_LIMIT = 4000;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             cfg_wen       = 1'b0;
    logic [IDX_W-1:0] cfg_index     = '0;
    logic [SBITS-1:0] cfg_data      = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [39:0]      s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    int               errors;
    int               results_seen;
    int               pending;
    int               sent_total    = 0;
    int               send_idle     = 0;
    int               recv_stall    = 0;
    int               hold_cycles   = 0;
    logic [SBITS-1:0] reg_plan [7];
    logic [SBITS-1:0] pedal_target [NUM_CH];

    pedal_plausibility_monitor_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pedal_plausibility_monitor_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .results_seen  (results_seen),
        .pending       (pending)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Result side: random stalls, or a counted hold-off when one is requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wen)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_pedal_plausibility_monitor_top: FAIL");
        $finish;
    end

    task automatic offer_item(input logic [SBITS-1:0] t1, input logic [SBITS-1:0] t2,
                              input logic [SBITS-1:0] br);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= {4'b0, br, t2, t1};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_total++;
    endtask

    // Drain every outstanding request before touching the settings
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (results_seen != sent_total)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic load_settings();
        for (int i = 0; i < 7; i++)
        begin
            cfg_wen   <= 1'b1;
            cfg_index <= IDX_W'(i);
            cfg_data  <= reg_plan[i];
            @(posedge clk);
        end
        // Index past the register list must be ignored
        cfg_index <= REG_UNUSED;
        cfg_data  <= SBITS'($urandom);
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [SBITS-1:0] pick_limit();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return SBITS'(FULL_SCALE);
            default: return SBITS'($urandom_range(0, FULL_SCALE));
        endcase
    endfunction

    function automatic logic [SBITS-1:0] pick_tolerance();
        logic [TOL_W-1:0] t;
        case ($urandom_range(0, 4))
            0:       t = '0;
            1:       t = TOL_W'(100);
            2:       t = '1;
            default: t = TOL_W'($urandom_range(0, 127));
        endcase
        // Upper bits are junk the block must drop
        return {(SBITS-TOL_W)'($urandom_range(0, 31)), t};
    endfunction

    // Pedals dwell on a position for a while; some readings are plain noise
    function automatic logic [SBITS-1:0] next_sample(input logic [CH_W-1:0] ch);
        if ($urandom_range(0, 99) < 15)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: pedal_target[ch] = '0;
                3, 4, 5: pedal_target[ch] = SBITS'(FULL_SCALE);
                default: pedal_target[ch] = SBITS'($urandom_range(0, FULL_SCALE));
            endcase
        end
        if ($urandom_range(0, 99) < 20)
            return SBITS'($urandom_range(0, FULL_SCALE));
        return pedal_target[ch];
    endfunction

    initial
    begin
        for (int i = 0; i < NUM_CH; i++)
            pedal_target[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limits: brake min above max pins brake at full travel
        offer_item('0, '0, '0);
        repeat (4) offer_item(SBITS'(FULL_SCALE), SBITS'(FULL_SCALE), SBITS'(FULL_SCALE));
        repeat (3) offer_item('0, SBITS'(FULL_SCALE), '0);
        repeat (2) offer_item(SBITS'(FULL_SCALE), '0, SBITS'(FULL_SCALE));
        settle();

        // Zero span on throttle 2, tolerance above 100, full-range brake
        reg_plan[REG_T1_MIN] = '0;
        reg_plan[REG_T1_MAX] = SBITS'(FULL_SCALE);
        reg_plan[REG_T2_MIN] = SBITS'(1000);
        reg_plan[REG_T2_MAX] = SBITS'(1000);
        reg_plan[REG_BR_MIN] = '0;
        reg_plan[REG_BR_MAX] = SBITS'(FULL_SCALE);
        reg_plan[REG_TOL]    = SBITS'(12'hf7f);
        load_settings();
        // Throttle with brake drops the latch, full release restores it
        repeat (3) offer_item(SBITS'(FULL_SCALE), SBITS'(FULL_SCALE), SBITS'(FULL_SCALE));
        repeat (8) offer_item('0, '0, '0);
        offer_item(SBITS'(FULL_SCALE), '0, '0);
        settle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 72; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 72; end
                default: begin send_idle = 38; recv_stall = 38; end
            endcase
            if (ph == 2)
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    reg_plan[2*c]   = '0;
                    reg_plan[2*c+1] = SBITS'(FULL_SCALE);
                end
                reg_plan[REG_TOL] = '0;
            end
            else if (ph == 5)
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    reg_plan[2*c]   = SBITS'(FULL_SCALE);
                    reg_plan[2*c+1] = '0;
                end
                reg_plan[REG_TOL] = SBITS'(127);
            end
            else
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    reg_plan[2*c]   = pick_limit();
                    reg_plan[2*c+1] = ($urandom_range(0, 4) == 0) ? reg_plan[2*c] : pick_limit();
                end
                reg_plan[REG_TOL] = pick_tolerance();
            end
            load_settings();
            // Hold the result side off long enough to back up the request side
            if (ph == 0)
                hold_cycles = HOLD_OFF;
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_item(next_sample(CH_T1), next_sample(CH_T2), next_sample(CH_BR));
            settle();
        end

        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_pedal_plausibility_monitor_top: PASS");
        else
            $display("tb_pedal_plausibility_monitor_top: FAIL");
        $finish;
    end

endmodule

@@ pedal_plausibility_monitor_top.f @@
rtl/core/ppm_pkg.sv
rtl/core/ppm_ctrl.sv
rtl/core/ppm_datapath.sv
rtl/core/pedal_plausibility_monitor_top.sv
test/pedal_plausibility_monitor_checker.sv
test/tb_pedal_plausibility_monitor_top.sv
